>>> rtl/mfv_pkg.sv
// ----------------------------------------------------------------------------
// mfv_pkg
// Shared widths, register codes, event codes and helpers for the metered
// fill valve controller.
// ----------------------------------------------------------------------------
package mfv_pkg;

	localparam int COUNT_BITS  = 20;
	localparam int TIME_BITS   = 30;
	localparam int TARGET_W    = 20;
	localparam int DEBOUNCE_W  = 20;
	localparam int MAXFILL_W   = 30;
	localparam int NOFLOW_W    = 30;
	localparam int JUGS_W      = 24;
	localparam int PCT_W       = 7;
	localparam int EVENT_W     = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 30;
	localparam int CMP_W       = 32;
	localparam int DIV_STEPS   = PCT_W;
	localparam int STEP_W      = 3;
	localparam int DIV_W       = ((COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W) + DIV_STEPS;
	localparam int S_TDATA_W   = 8;
	localparam int M_OUT_W     = 1 + EVENT_W + PCT_W + JUGS_W;
	localparam int M_TDATA_W   = ((M_OUT_W + 7) / 8) * 8;

	localparam logic [PCT_W-1:0]      PCT_FULL         = PCT_W'(100);
	localparam logic [TARGET_W-1:0]   TARGET_RST       = TARGET_W'(7078);
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST     = DEBOUNCE_W'(1000);
	localparam logic [MAXFILL_W-1:0]  MAXFILL_RST      = MAXFILL_W'(180000000);
	localparam logic [NOFLOW_W-1:0]   NOFLOW_RST       = NOFLOW_W'(10000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET   = 2'd0,
		CFG_DEBOUNCE = 2'd1,
		CFG_MAX_FILL = 2'd2,
		CFG_NO_FLOW  = 2'd3
	} cfg_index_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE      = 3'd0,
		EV_STARTED   = 3'd1,
		EV_COMPLETED = 3'd2,
		EV_TIMEOUT   = 3'd3,
		EV_NO_FLOW   = 3'd4,
		EV_CANCELED  = 3'd5
	} event_t;

	typedef struct packed {
		logic [TARGET_W-1:0]   target;
		logic [DEBOUNCE_W-1:0] debounce;
		logic [MAXFILL_W-1:0]  max_fill;
		logic [NOFLOW_W-1:0]   no_flow;
	} cfg_t;

	typedef struct packed {
		logic                  valve_open;
		event_t                event_code;
		logic [COUNT_BITS-1:0] pulse_total;
		logic [JUGS_W-1:0]     jugs_done;
	} tick_res_t;

	function automatic logic [TIME_BITS-1:0] time_inc(input logic [TIME_BITS-1:0] v);
		return (&v) ? v : v + TIME_BITS'(1);
	endfunction

	function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

endpackage

>>> rtl/mfv_tick.sv
// ----------------------------------------------------------------------------
// mfv_tick
// Per-tick state update: debounced pulse counting, fill supervision and
// button handling. State advances once per upd strobe.
// ----------------------------------------------------------------------------
module mfv_tick
	import mfv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      upd,
	input  logic      flow_edge,
	input  logic      button_down,
	input  cfg_t      cfg,
	output tick_res_t res
);

	logic                  fill_q, fill_n;
	logic                  rel_q, rel_n;
	logic [COUNT_BITS-1:0] pt_q, pt_n;
	logic [COUNT_BITS-1:0] lsp_q, lsp_n;
	logic [TIME_BITS-1:0]  tsp_q, tsp_n;
	logic [TIME_BITS-1:0]  fe_q, fe_n;
	logic [TIME_BITS-1:0]  tsf_q, tsf_n;
	logic [JUGS_W-1:0]     jugs_q, jugs_n;
	event_t                ev_q, ev_n;

	always_comb begin
		fill_n = fill_q;
		rel_n  = rel_q;
		pt_n   = pt_q;
		lsp_n  = lsp_q;
		fe_n   = fe_q;
		tsf_n  = tsf_q;
		jugs_n = jugs_q;
		ev_n   = EV_NONE;
		tsp_n  = time_inc(tsp_q);
		if (flow_edge && (CMP_W'(tsp_n) > CMP_W'(cfg.debounce))) begin
			pt_n  = count_inc(pt_q);
			tsp_n = '0;
		end
		if (fill_q) begin
			fe_n  = time_inc(fe_q);
			tsf_n = time_inc(tsf_q);
			if (CMP_W'(pt_n) >= CMP_W'(cfg.target)) begin
				fill_n = 1'b0;
				jugs_n = jugs_q + JUGS_W'(1);
				ev_n   = EV_COMPLETED;
			end else if (CMP_W'(fe_n) > CMP_W'(cfg.max_fill)) begin
				fill_n = 1'b0;
				ev_n   = EV_TIMEOUT;
			end else if ((pt_n == lsp_q) && (CMP_W'(tsf_n) > CMP_W'(cfg.no_flow))) begin
				fill_n = 1'b0;
				ev_n   = EV_NO_FLOW;
			end else if (pt_n != lsp_q) begin
				lsp_n = pt_n;
				tsf_n = '0;
			end
		end
		if (button_down && rel_q) begin
			rel_n = 1'b0;
			if (!fill_n) begin
				pt_n   = '0;
				fill_n = 1'b1;
				fe_n   = '0;
				lsp_n  = '0;
				tsf_n  = '0;
				ev_n   = EV_STARTED;
			end else begin
				fill_n = 1'b0;
				ev_n   = EV_CANCELED;
			end
		end else if (!button_down) begin
			rel_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b0;
			rel_q  <= 1'b1;
			pt_q   <= '0;
			lsp_q  <= '0;
			tsp_q  <= '0;
			fe_q   <= '0;
			tsf_q  <= '0;
			jugs_q <= '0;
			ev_q   <= EV_NONE;
		end else if (upd) begin
			fill_q <= fill_n;
			rel_q  <= rel_n;
			pt_q   <= pt_n;
			lsp_q  <= lsp_n;
			tsp_q  <= tsp_n;
			fe_q   <= fe_n;
			tsf_q  <= tsf_n;
			jugs_q <= jugs_n;
			ev_q   <= ev_n;
		end
	end

	assign res.valve_open  = fill_q;
	assign res.event_code  = ev_q;
	assign res.pulse_total = pt_q;
	assign res.jugs_done   = jugs_q;

`ifndef SYNTH
	a_event_valve: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_q != EV_NONE) |-> (fill_q == (ev_q == EV_STARTED)))
		else $error("valve state disagrees with event code");
`endif

endmodule

>>> rtl/mfv_div.sv
// ----------------------------------------------------------------------------
// mfv_div
// Restoring divider for the fill percentage: pulse_total * 100 / target,
// one quotient bit per cycle, clamped to 100 when the target is reached.
// ----------------------------------------------------------------------------
module mfv_div
	import mfv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] pulse_total,
	input  logic [TARGET_W-1:0]   target,
	output logic                  done,
	output logic [PCT_W-1:0]      percent
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [PCT_W-1:0]  quo_q;
	logic              full;

	assign full = (CMP_W'(pulse_total) >= CMP_W'(target));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (full) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(DIV_STEPS - 1);
				end
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_W'(pulse_total) * DIV_W'(100);
			dsh_q <= DIV_W'(target) << (DIV_STEPS - 1);
			quo_q <= full ? PCT_FULL : '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[PCT_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[PCT_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done    = done_q;
	assign percent = quo_q;

`ifndef SYNTH
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (quo_q <= PCT_FULL))
		else $error("percent above full scale");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");
	a_step_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> (step_q == STEP_W'(DIV_STEPS - 1)))
		else $error("divider step count not loaded");
`endif

endmodule

>>> rtl/metered_fill_valve_controller_core.sv
// ----------------------------------------------------------------------------
// metered_fill_valve_controller_core
// Tick-driven fill valve controller with debounced flow counting, time and
// no-flow supervision, button start/cancel and percent progress output.
// ----------------------------------------------------------------------------
// Sequence: ticks are taken only in S_IDLE; each then passes S_TICK, S_START and
//   S_WAIT to S_OUT, which registers the result and raises tvalid, waiting while
//   a result stalls. The seven-step restoring divider forms the percentage and
//   skips its steps when progress is already full (pulse count at or above target).
// Reset: arst_n clears control and output state and loads config defaults.
module metered_fill_valve_controller_core
	import mfv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // flow_edge, button_down
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // valve_open, event_code,
	                                             // progress_percent, jugs_done
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_START,
		S_WAIT,
		S_OUT
	} state_t;

	state_t                state_q;
	cfg_t                  cfg_q;
	logic                  flow_q;
	logic                  button_q;
	logic                  out_valid_q;
	logic [M_TDATA_W-1:0]  out_data_q;
	tick_res_t             res;
	logic                  div_done;
	logic [PCT_W-1:0]      pct;
	logic                  in_xfer;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target   <= TARGET_RST;
			cfg_q.debounce <= DEBOUNCE_RST;
			cfg_q.max_fill <= MAXFILL_RST;
			cfg_q.no_flow  <= NOFLOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET:   cfg_q.target   <= cfg_data[TARGET_W-1:0];
				CFG_DEBOUNCE: cfg_q.debounce <= cfg_data[DEBOUNCE_W-1:0];
				CFG_MAX_FILL: cfg_q.max_fill <= cfg_data[MAXFILL_W-1:0];
				CFG_NO_FLOW:  cfg_q.no_flow  <= cfg_data[NOFLOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			flow_q   <= s_axis_tdata[0];
			button_q <= s_axis_tdata[1];
		end
	end

	mfv_tick u_tick (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (state_q == S_TICK),
		.flow_edge   (flow_q),
		.button_down (button_q),
		.cfg         (cfg_q),
		.res         (res)
	);

	mfv_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (state_q == S_START),
		.pulse_total (res.pulse_total),
		.target      (cfg_q.target),
		.done        (div_done),
		.percent     (pct)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_TICK;
					end
				end
				S_TICK: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= M_TDATA_W'({res.jugs_done, pct,
							res.event_code, res.valve_open});
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_axis_tready)
		else $error("input accepted while a tick is in progress");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_WAIT))
		else $error("divider finished outside the wait step");
`endif

endmodule
